// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the span builder modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/prsb_pkg.sv =====
// Types and constants for the polygon row span builder.
// No dependencies.
package prsb_pkg;
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_CLOSE  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam int XW = 12;
    localparam int RW = 11;
    localparam int SW = 13;
    localparam int KW = 13; // step counter, up to 2047 plus one
    localparam logic signed [SW-1:0] UNSET = -13'sd1;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;      // latch accepted item
        logic first_set;    // remember first vertex
        logic edge_start;   // set up edge walk (from prev to target)
        logic use_first;    // target is the first vertex
        logic div_start;    // start division for current step
        logic rd_issue;     // issue memory read for current row
        logic wr_issue;     // write merged row
        logic step_adv;     // advance row and k
        logic prev_update;  // prev <= target
        logic clr_issue;    // clear one row
        logic rsp_load;     // load result register
    } prsb_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic div_done;
        logic last_step;
        logic horiz;
        logic clr_last;
    } prsb_sts_t;
endpackage

// ===== rtl/prsb_div.sv =====
// Restoring divider, one quotient bit per cycle, for edge x interpolation.
// Depends on nothing but the clock domain.
module prsb_div #(
    parameter int NW = 24,
    parameter int DW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start) begin
            q_next = num;
            r_next = '0;
            d_next = den;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) busy_reg <= 1'b0;
        else busy_reg <= busy_next;
    end

    assign done = !busy_reg;
    assign quo  = q_reg;
endmodule

// ===== rtl/prsb_datapath.sv =====
// Datapath: vertex registers, edge walker, divider and span memories.
// Depends on prsb_pkg, prsb_div and assert_macros.svh.
`include "assert_macros.svh"
module prsb_datapath #(
    parameter int ROWS = 2048,
    parameter int COLS = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  prsb_pkg::prsb_cmd_t          cmd,
    output prsb_pkg::prsb_sts_t          sts,
    input  logic [1:0]                   s_kind,
    input  logic [prsb_pkg::XW-1:0]      s_point_x,
    input  logic [prsb_pkg::RW-1:0]      s_point_row,
    output logic [1:0]                   kind_q,
    output logic                         rd_oob,
    output logic signed [prsb_pkg::SW-1:0] rd_left,
    output logic signed [prsb_pkg::SW-1:0] rd_right
);
    localparam int XW = prsb_pkg::XW;
    localparam int RW = prsb_pkg::RW;
    localparam int SW = prsb_pkg::SW;
    localparam int KW = prsb_pkg::KW;
    localparam int AW = $clog2(ROWS);
    localparam int NW = XW + KW;

    logic [XW-1:0] in_x_reg;
    logic [RW-1:0] in_row_reg;
    logic [1:0]    kind_reg;
    logic [XW-1:0] first_x_reg, prev_x_reg, tx_reg;
    logic [RW-1:0] first_row_reg, prev_row_reg, trow_reg;
    logic [RW-1:0] row_reg;
    logic [KW-1:0] k_reg;
    logic          up_reg, neg_reg;
    logic [XW-1:0] adx_reg, dy_reg;
    logic [AW-1:0] clr_reg;
    logic signed [SW-1:0] left_mem [ROWS];
    logic signed [SW-1:0] right_mem [ROWS];
    logic signed [SW-1:0] lrd_reg, rrd_reg;
    logic signed [SW-1:0] v;
    logic [NW-1:0] quo;
    logic          div_done;
    logic [XW-1:0] sat_x;
    logic [RW-1:0] tgt_row;
    logic [XW-1:0] tgt_x;
    logic          row_ok;
    logic signed [SW-1:0] wl, wr;
    logic [AW-1:0] addr;

    assign sat_x = (s_point_x > XW'(COLS - 1)) ? XW'(COLS - 1) : s_point_x;
    assign tgt_row = cmd.use_first ? first_row_reg : in_row_reg;
    assign tgt_x   = cmd.use_first ? first_x_reg : in_x_reg;

    prsb_div #(.NW(NW), .DW(XW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(NW'(adx_reg) * NW'(k_reg)), .den(dy_reg),
        .done(div_done), .quo(quo)
    );

    // trunc toward zero: apply sign to magnitude quotient
    always_comb begin
        if (neg_reg) v = SW'($signed({1'b0, prev_x_reg})) - SW'(quo);
        else v = SW'($signed({1'b0, prev_x_reg})) + SW'(quo);
    end

    always_comb begin
        wl = lrd_reg;
        wr = rrd_reg;
        if (lrd_reg == prsb_pkg::UNSET && !up_reg) begin
            wl = v;
        end else begin
            if (lrd_reg == prsb_pkg::UNSET || lrd_reg <= v) begin
                wl = (lrd_reg == prsb_pkg::UNSET) ? v : lrd_reg;
                wr = v;
            end else begin
                wl = v;
                wr = lrd_reg;
            end
        end
        if (sts.horiz) begin
            if (tx_reg > prev_x_reg) begin
                wl = SW'($signed({1'b0, prev_x_reg}));
                wr = SW'($signed({1'b0, tx_reg}));
            end else begin
                wl = SW'($signed({1'b0, tx_reg}));
                wr = SW'($signed({1'b0, prev_x_reg}));
            end
        end
    end

    assign row_ok = (32'(row_reg) < ROWS);
    assign addr = cmd.clr_issue ? clr_reg : (cmd.rsp_load || kind_reg == prsb_pkg::KIND_READ)
                  ? AW'(in_row_reg) : AW'(row_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_kind;
            in_x_reg <= sat_x;
            in_row_reg <= s_point_row;
        end
        if (cmd.first_set) begin
            first_x_reg <= in_x_reg;
            first_row_reg <= in_row_reg;
        end
        if (cmd.edge_start) begin
            tx_reg <= tgt_x;
            trow_reg <= tgt_row;
            row_reg <= prev_row_reg;
            k_reg <= '0;
            up_reg <= tgt_row < prev_row_reg;
            neg_reg <= tgt_x < prev_x_reg;
            adx_reg <= (tgt_x < prev_x_reg) ? prev_x_reg - tgt_x : tgt_x - prev_x_reg;
            dy_reg <= XW'((tgt_row < prev_row_reg) ? prev_row_reg - tgt_row
                                                   : tgt_row - prev_row_reg);
        end
        if (cmd.step_adv) begin
            k_reg <= k_reg + 1'b1;
            row_reg <= up_reg ? row_reg - 1'b1 : row_reg + 1'b1;
        end
        if (cmd.prev_update) begin
            prev_x_reg <= tgt_x;
            prev_row_reg <= tgt_row;
        end
        if (cmd.rd_issue || cmd.rsp_load) begin
            lrd_reg <= left_mem[addr];
            rrd_reg <= right_mem[addr];
        end
        if (cmd.clr_issue) begin
            left_mem[addr] <= prsb_pkg::UNSET;
            right_mem[addr] <= prsb_pkg::UNSET;
        end else if (cmd.wr_issue && row_ok && !(sts.horiz && tx_reg == prev_x_reg)) begin
            left_mem[addr] <= wl;
            right_mem[addr] <= wr;
        end
        if (!aresetn) begin
            clr_reg <= '0;
            prev_x_reg <= '0;
            prev_row_reg <= '0;
            first_x_reg <= '0;
            first_row_reg <= '0;
        end else if (cmd.clr_issue) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign sts.div_done  = div_done;
    assign sts.last_step = (row_reg == trow_reg);
    assign sts.horiz     = (trow_reg == prev_row_reg) && (k_reg == '0) && (row_reg == trow_reg);
    assign sts.clr_last  = (32'(clr_reg) == ROWS - 1);
    assign kind_q = kind_reg;
    assign rd_oob = !(32'(in_row_reg) < ROWS);
    assign rd_left  = lrd_reg;
    assign rd_right = rrd_reg;
endmodule

// ===== rtl/prsb_ctrl.sv =====
// Controller state machine for the span builder.
// Depends on prsb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module prsb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_status,
    output logic                 m_is_closed,
    output logic                 rd_sel,
    input  logic [1:0]           kind_q,
    output prsb_pkg::prsb_cmd_t  cmd,
    input  prsb_pkg::prsb_sts_t  sts
);
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DEC   = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_WAIT  = 4'd4;
    localparam logic [3:0] ST_READ  = 4'd5;
    localparam logic [3:0] ST_WRITE = 4'd6;
    localparam logic [3:0] ST_RDOUT = 4'd7;
    localparam logic [3:0] ST_RESP  = 4'd8;
    localparam logic [3:0] ST_RDLAT = 4'd9;

    logic [3:0] state_reg, state_next;
    logic have_reg, have_next, closed_reg, closed_next;
    logic stat_reg, stat_next, close_op_reg, close_op_next;
    logic mv_reg, mv_next;

    always_comb begin
        state_next = state_reg;
        have_next = have_reg;
        closed_next = closed_reg;
        stat_next = stat_reg;
        close_op_next = close_op_reg;
        mv_next = mv_reg;
        cmd = '0;
        cmd.use_first = close_op_reg;
        rd_sel = 1'b0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_issue = 1'b1;
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && !mv_reg) begin
                    cmd.capture = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                stat_next = 1'b1;
                close_op_next = 1'b0;
                state_next = ST_RESP;
                case (kind_q)
                    prsb_pkg::KIND_VERTEX: if (!closed_reg) begin
                        stat_next = 1'b0;
                        if (have_reg) begin
                            cmd.edge_start = 1'b1;
                            state_next = ST_DIV;
                        end else begin
                            cmd.first_set = 1'b1;
                            cmd.prev_update = 1'b1;
                            have_next = 1'b1;
                        end
                    end
                    prsb_pkg::KIND_CLOSE: if (!closed_reg && have_reg) begin
                        stat_next = 1'b0;
                        close_op_next = 1'b1;
                        cmd.use_first = 1'b1;
                        cmd.edge_start = 1'b1;
                        closed_next = 1'b1;
                        state_next = ST_DIV;
                    end
                    prsb_pkg::KIND_READ: begin
                        stat_next = 1'b0;
                        state_next = ST_RDOUT;
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.div_done) begin
                    cmd.rd_issue = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.wr_issue = 1'b1;
                if (sts.last_step) begin
                    cmd.prev_update = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.step_adv = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_RDOUT: begin
                rd_sel = 1'b1;
                cmd.rsp_load = 1'b1;
                state_next = ST_RDLAT;
            end
            ST_RDLAT: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                mv_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            have_reg <= 1'b0;
            closed_reg <= 1'b0;
            stat_reg <= 1'b0;
            close_op_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            have_reg <= have_next;
            closed_reg <= closed_next;
            stat_reg <= stat_next;
            close_op_reg <= close_op_next;
            mv_reg <= mv_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_status = stat_reg;
    assign m_is_closed = closed_reg;

    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, mv_reg, !s_ready)
    `ASSERT_NEXT(a_close_sticks, aclk, aresetn, closed_reg, closed_reg)
    `ASSERT_IMPL(a_clear_quiet, aclk, aresetn, state_reg == ST_CLEAR, !mv_reg && !s_ready)
endmodule

// ===== rtl/polygon_row_span_builder.sv =====
// Top level of the polygon row span builder: controller plus datapath.
// Depends on prsb_pkg, prsb_ctrl, prsb_datapath.
//
//  channel | handshake           | payload
//  s_      | s_valid / s_ready   | s_kind, s_point_x, s_point_row
//  m_      | m_valid / m_ready   | m_status, m_span_left, m_span_right, m_is_closed
//
// After reset a clearing pass writes -1 to every row; no transfer is taken meanwhile.
// Ignored items and a first vertex pass decode and the response state before m_valid
// rises; reads also pass the read-out and read-latency states. Each row an edge walks,
// its last included, takes a bit-serial division (NW = 25) plus a read and a write.
// One item is in flight at a time; a pending result blocks the next transfer.
module polygon_row_span_builder #(
    parameter int ROWS = 2048,
    parameter int COLS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [11:0] s_point_x,
    input  logic [10:0] s_point_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic signed [12:0] m_span_left,
    output logic signed [12:0] m_span_right,
    output logic        m_is_closed
);
    prsb_pkg::prsb_cmd_t cmd;
    prsb_pkg::prsb_sts_t sts;
    logic [1:0] kind_q;
    logic rd_oob, rd_sel;
    logic signed [12:0] dl, dr;
    logic signed [12:0] sl_reg, sr_reg;
    logic rdv_reg;

    prsb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_is_closed(m_is_closed), .rd_sel(rd_sel), .kind_q(kind_q), .cmd(cmd), .sts(sts)
    );

    prsb_datapath #(.ROWS(ROWS), .COLS(COLS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .s_kind(s_kind),
        .s_point_x(s_point_x), .s_point_row(s_point_row), .kind_q(kind_q),
        .rd_oob(rd_oob), .rd_left(dl), .rd_right(dr)
    );

    // Capture read data in the cycle after the memory read; zero for other items.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdv_reg <= 1'b0;
            sl_reg <= '0;
            sr_reg <= '0;
        end else begin
            rdv_reg <= rd_sel;
            if (s_valid && s_ready) begin
                sl_reg <= '0;
                sr_reg <= '0;
            end else if (rdv_reg) begin
                sl_reg <= rd_oob ? prsb_pkg::UNSET : dl;
                sr_reg <= rd_oob ? prsb_pkg::UNSET : dr;
            end
        end
    end

    assign m_span_left  = sl_reg;
    assign m_span_right = sr_reg;
endmodule
